>>> src/char_lcd_write_sequencer_top_macros.svh
// Assertion macros for the character LCD write sequencer checker.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef CHAR_LCD_WRITE_SEQUENCER_TOP_MACROS_SVH
`define CHAR_LCD_WRITE_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, off during reset.
`define LCDWS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lcdws assertion failed");

// Next-cycle implication, off during reset.
`define LCDWS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lcdws assertion failed");

// Holds in the cycle after reset is applied.
`define LCDWS_ASSERT_RESET(label, cons) \
    label: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error("lcdws assertion failed");

`endif

>>> src/lcdws_pkg.sv
// Package for the character LCD write sequencer: word types, codes, tables.
// No dependencies.
`default_nettype none
package lcdws_pkg;

    localparam logic [2:0] FUNC_CMD  = 3'd0;
    localparam logic [2:0] FUNC_CHAR = 3'd1;
    localparam logic [2:0] FUNC_POS  = 3'd2;
    localparam logic [2:0] FUNC_SLOT = 3'd3;
    localparam logic [2:0] FUNC_INIT = 3'd4;

    localparam logic [7:0] ROW_BASE_ONE   = 8'h80;
    localparam logic [7:0] ROW_BASE_TWO   = 8'hC0;
    localparam logic [7:0] ROW_BASE_THREE = 8'h94;
    localparam logic [7:0] ROW_BASE_FOUR  = 8'd212;

    localparam logic [7:0] CGRAM_BASE  = 8'h40;
    localparam logic [7:0] MODE_FOUR   = 8'h28;
    localparam logic [7:0] MODE_EIGHT  = 8'h38;
    localparam logic [3:0] INIT_MODE_IDX = 4'd7;
    localparam logic [3:0] INIT_LAST_IDX = 4'd8;
    localparam logic [3:0] INIT_PAUSE_CNT = 4'd3;

    localparam logic [1:0] PAUSE_NONE = 2'd0;

    localparam int JOB_DEPTH = 4;
    localparam int JOB_AW    = $clog2(JOB_DEPTH);

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] value;
        logic [2:0] row;
        logic [5:0] column;
    } t_in_word;

    typedef struct packed {
        logic       reg_select;
        logic [7:0] bus_value;
        logic [1:0] pause_before;
        logic       last;
    } t_out_word;

    // One classified request for the back end.
    typedef struct packed {
        logic       init;
        logic       two_bytes;
        logic       rs0;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_job;

    function automatic logic [7:0] power_seq(input logic [3:0] idx, input logic bus_mode);
        logic [7:0] b;
        unique case (idx)
            4'd0, 4'd1, 4'd2: b = 8'h38;
            4'd3:             b = 8'h01;
            4'd4:             b = 8'h02;
            4'd5:             b = 8'h06;
            4'd6:             b = 8'h0C;
            INIT_MODE_IDX:    b = bus_mode ? MODE_EIGHT : MODE_FOUR;
            INIT_LAST_IDX:    b = 8'h80;
            default:          b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

>>> src/char_lcd_write_sequencer_top.sv
// Character LCD write sequencer, top level: bus mode register, front end,
// job queue and back end. Depends on lcdws_pkg and the lcdws_* modules.
//
// Requests go in on i_item with push/full; strobe words come out on o_res with
// empty/pop, oldest first, one word per enable strobe, last set on the final
// strobe of each request. Unused func codes are taken and give no words.
// A request pushed into an idle block passes through both registered queues
// before its first word shows. The front end takes one request per cycle while
// the four-entry job queue has room; the back end sends one strobe word per
// cycle while the result queue has room. A request gives 1 or 2 strobes for a
// command, character or glyph slot, 1 to 4 for a positioned character, 9 or
// 18 for power-up. When pop is held low the two-entry result queue fills, the
// back end stops, then the job queue fills and full rises; nothing is lost.
// i_cfg_we writes i_cfg_data into bus_mode (0 four lines, 1 eight lines); write
// it only while idle. Synchronous reset empties both queues and clears bus_mode.
`default_nettype none
module char_lcd_write_sequencer_top (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire                  i_cfg_data,
    input  wire                  push,
    output logic                 full,
    input  lcdws_pkg::t_in_word  i_item,
    output logic                 empty,
    input  wire                  pop,
    output lcdws_pkg::t_out_word o_res
);
    import lcdws_pkg::*;

    logic     r_bus_mode;
    logic     q_full, job_push;
    logic     job_valid, job_pop;
    t_job     job_in, job_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_bus_mode <= i_cfg_data;
        end
    end

    lcdws_front u_front (
        .i_push     (push),
        .i_item     (i_item),
        .i_q_full   (q_full),
        .o_full     (full),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    lcdws_job_fifo u_jobq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (job_push),
        .i_job     (job_in),
        .o_full    (q_full),
        .i_pop     (job_pop),
        .o_valid   (job_valid),
        .o_job     (job_head)
    );

    lcdws_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bus_mode  (r_bus_mode),
        .i_job_valid (job_valid),
        .i_job       (job_head),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (o_res)
    );
endmodule
`default_nettype wire

>>> src/lcdws_front.sv
// Front end: classifies request words into byte jobs.
// Depends on lcdws_pkg.
`default_nettype none
module lcdws_front (
    input  wire                  i_push,
    input  lcdws_pkg::t_in_word  i_item,
    input  wire                  i_q_full,
    output logic                 o_full,
    output logic                 o_job_push,
    output lcdws_pkg::t_job      o_job
);
    import lcdws_pkg::*;

    logic       row_ok;
    logic [7:0] base;
    logic       has_job;

    always_comb begin
        row_ok = 1'b1;
        unique case (i_item.row)
            3'd1:    base = ROW_BASE_ONE;
            3'd2:    base = ROW_BASE_TWO;
            3'd3:    base = ROW_BASE_THREE;
            3'd4:    base = ROW_BASE_FOUR;
            default: begin
                base   = 8'h00;
                row_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_job   = '0;
        has_job = 1'b1;
        unique case (i_item.func)
            FUNC_CMD: begin
                o_job.b0 = i_item.value;
            end
            FUNC_CHAR: begin
                o_job.rs0 = 1'b1;
                o_job.b0  = i_item.value;
            end
            FUNC_POS: begin
                if (row_ok) begin
                    o_job.two_bytes = 1'b1;
                    o_job.b0 = 8'(base + {2'b00, i_item.column} - 8'd1);
                    o_job.b1 = i_item.value;
                end else begin
                    o_job.rs0 = 1'b1;
                    o_job.b0  = i_item.value;
                end
            end
            FUNC_SLOT: begin
                o_job.b0 = CGRAM_BASE + {i_item.value[4:0], 3'b000};
            end
            FUNC_INIT: begin
                o_job.init = 1'b1;
            end
            default: has_job = 1'b0;
        endcase
    end

    assign o_full     = i_q_full;
    assign o_job_push = i_push && !i_q_full && has_job;
endmodule
`default_nettype wire

>>> src/lcdws_job_fifo.sv
// Short job queue between front and back ends.
// Depends on lcdws_pkg.
`default_nettype none
module lcdws_job_fifo (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  lcdws_pkg::t_job      i_job,
    output logic                 o_full,
    input  wire                  i_pop,
    output logic                 o_valid,
    output lcdws_pkg::t_job      o_job
);
    import lcdws_pkg::*;

    t_job              r_mem [JOB_DEPTH];
    logic [JOB_AW-1:0] r_wr, r_rd;
    logic [JOB_AW:0]   r_cnt;
    logic              do_pop;

    assign o_full  = (r_cnt == (JOB_AW+1)'(JOB_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (JOB_AW+1)'(i_push) - (JOB_AW+1)'(do_pop);
        end
    end
endmodule
`default_nettype wire

>>> src/lcdws_back.sv
// Back end: walks each job byte by byte and nibble by nibble, one strobe word
// a cycle into a two-entry result queue when not full. Depends on lcdws_pkg.
`default_nettype none
module lcdws_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_bus_mode,
    input  wire                  i_job_valid,
    input  lcdws_pkg::t_job      i_job,
    output logic                 o_job_pop,
    input  wire                  i_pop,
    output logic                 o_empty,
    output lcdws_pkg::t_out_word o_res
);
    import lcdws_pkg::*;

    logic [3:0] r_idx;
    logic       r_nib;
    t_out_word  r_q [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;

    logic [7:0] cur_byte;
    logic       byte_last;
    logic       emit, do_pop;
    t_out_word  word;

    always_comb begin
        if (i_job.init) begin
            cur_byte  = power_seq(r_idx, i_bus_mode);
            byte_last = (r_idx == INIT_LAST_IDX);
            word.reg_select = 1'b0;
        end else begin
            cur_byte  = r_idx[0] ? i_job.b1 : i_job.b0;
            byte_last = i_job.two_bytes ? r_idx[0] : 1'b1;
            word.reg_select = r_idx[0] ? 1'b1 : i_job.rs0;
        end
        if (i_bus_mode) begin
            word.bus_value = cur_byte;
        end else begin
            word.bus_value = {4'h0, r_nib ? cur_byte[3:0] : cur_byte[7:4]};
        end
        if (i_job.init && !r_nib && r_idx < INIT_PAUSE_CNT) begin
            word.pause_before = r_idx[1:0] + 2'd1;
        end else begin
            word.pause_before = PAUSE_NONE;
        end
        word.last = byte_last && (i_bus_mode || r_nib);
    end

    assign emit      = i_job_valid && (r_cnt != 2'd2);
    assign o_job_pop = emit && word.last;
    assign do_pop    = i_pop && !o_empty;
    assign o_empty   = (r_cnt == 2'd0);
    assign o_res     = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_q[r_wr] <= word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_nib <= 1'b0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (emit) begin
                r_wr <= ~r_wr;
                if (i_bus_mode || r_nib) begin
                    r_nib <= 1'b0;
                    r_idx <= word.last ? 4'd0 : r_idx + 4'd1;
                end else begin
                    r_nib <= 1'b1;
                end
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(emit) - 2'(do_pop);
        end
    end
endmodule
`default_nettype wire

>>> src/lcdws_checker.sv
// Port-level checker for the character LCD write sequencer, with its bind.
// Depends on lcdws_pkg and char_lcd_write_sequencer_top_macros.svh.
`default_nettype none
`include "char_lcd_write_sequencer_top_macros.svh"
module lcdws_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_cfg_we,
    input wire                  i_cfg_data,
    input wire                  push,
    input wire                  full,
    input lcdws_pkg::t_in_word  i_item,
    input wire                  empty,
    input wire                  pop,
    input lcdws_pkg::t_out_word o_res
);
    import lcdws_pkg::*;

    `LCDWS_ASSERT_RESET(a_reset_empty, empty && !full)
    `LCDWS_ASSERT_NEXT(a_stall_hold, !empty && !pop, !empty && $stable(o_res))
    `LCDWS_ASSERT_IMPL(a_pause_instr, !empty && o_res.pause_before != PAUSE_NONE, !o_res.reg_select)
    `LCDWS_ASSERT_IMPL(a_pause_not_last, !empty && o_res.pause_before != PAUSE_NONE, !o_res.last)
endmodule

bind char_lcd_write_sequencer_top lcdws_checker u_lcdws_checker (.*);
`default_nettype wire
